>>> rtl/spmt_pkg.sv
// ----------------------------------------------------------------------------
// spmt_pkg
// Shared types and codes for the subnet prefix match table.
// ----------------------------------------------------------------------------
package spmt_pkg;

    localparam int unsigned KEY_W     = 128;
    localparam int unsigned V4_ADDR_W = 32;
    localparam int unsigned V4_PLEN_W = 6;
    localparam int unsigned V6_PLEN_W = 8;
    localparam int unsigned V4_MAX_PLEN = 32;
    localparam int unsigned V6_MAX_PLEN = 128;

    typedef enum logic [2:0] {
        REQ_ADD_V4    = 3'd0,
        REQ_ADD_V6    = 3'd1,
        REQ_CLEAR     = 3'd2,
        REQ_LOOKUP_V4 = 3'd3,
        REQ_LOOKUP_V6 = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_TOO_LONG = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [7:0]  prefix_length;
    } spmt_in_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] entry_index;
        logic [1:0] status;
    } spmt_out_t;

endpackage

>>> rtl/subnet_prefix_match_table_unit.sv
// ----------------------------------------------------------------------------
// subnet_prefix_match_table_unit
// Two ordered first-match prefix tables (IPv4, IPv6) with add, clear and
// lookup requests. Lookups scan one entry per cycle through a shared compare.
// ----------------------------------------------------------------------------
//  channel | ports                      | transfer
//  --------+----------------------------+-------------------------------
//  request | s_valid s_ready s_payload  | one request item
//  result  | m_valid m_ready m_payload  | one result item per request
//
//  Add, clear, unused codes, empty-table and IPv4 zero-address lookups: result
//  registered in the cycle after the transfer. Other lookups read entries in
//  order through the single RAM read port per table into the one compare
//  unit and stop at the first hit or after the last entry. Reset clears both
//  counts and the sequencer; the tables need no clearing. No new request is
//  taken while a lookup runs or while a result waits on m_ready.
// ----------------------------------------------------------------------------
module subnet_prefix_match_table_unit #(
    parameter int unsigned V4_ENTRIES = 16,
    parameter int unsigned V6_ENTRIES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spmt_pkg::spmt_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output spmt_pkg::spmt_out_t m_payload
);

    localparam int unsigned V4_AW = (V4_ENTRIES > 1) ? $clog2(V4_ENTRIES) : 1;
    localparam int unsigned V6_AW = (V6_ENTRIES > 1) ? $clog2(V6_ENTRIES) : 1;
    localparam int unsigned V4_CW = $clog2(V4_ENTRIES + 1);
    localparam int unsigned V6_CW = $clog2(V6_ENTRIES + 1);
    localparam int unsigned CW    = (V4_CW > V6_CW) ? V4_CW : V6_CW;
    localparam int unsigned V4_W  = spmt_pkg::V4_ADDR_W + spmt_pkg::V4_PLEN_W;
    localparam int unsigned V6_W  = spmt_pkg::KEY_W + spmt_pkg::V6_PLEN_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_CMP   = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [V4_CW-1:0]           v4_count_reg, v4_count_next;
    logic [V6_CW-1:0]           v6_count_reg, v6_count_next;
    logic [CW-1:0]              ptr_reg, ptr_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [CW-1:0]              cmp_idx_reg, cmp_idx_next;
    logic                       fam_v6_reg, fam_v6_next;
    logic [spmt_pkg::KEY_W-1:0] key_reg, key_next;
    logic                       m_valid_reg, m_valid_next;
    spmt_pkg::spmt_out_t        m_payload_reg, m_payload_next;

    logic                       accept;
    logic                       v4_we, v6_we, v4_re, v6_re, scan_rd;
    logic [V4_W-1:0]            v4_rdata;
    logic [V6_W-1:0]            v6_rdata;
    logic [spmt_pkg::KEY_W-1:0] ent_net;
    logic [7:0]                 ent_plen;
    logic                       match;
    logic                       v4_full, v6_full;

    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign v4_full = (v4_count_reg >= V4_CW'(V4_ENTRIES));
    assign v6_full = (v6_count_reg >= V6_CW'(V6_ENTRIES));

    assign v4_we = accept && (s_payload.req_type == spmt_pkg::REQ_ADD_V4)
                   && (s_payload.prefix_length <= 8'(spmt_pkg::V4_MAX_PLEN)) && !v4_full;
    assign v6_we = accept && (s_payload.req_type == spmt_pkg::REQ_ADD_V6)
                   && (s_payload.prefix_length <= 8'(spmt_pkg::V6_MAX_PLEN)) && !v6_full;

    assign scan_rd = ((state_reg == ST_FETCH) || (state_reg == ST_CMP)) && (ptr_reg < cnt_reg);
    assign v4_re   = scan_rd && !fam_v6_reg;
    assign v6_re   = scan_rd && fam_v6_reg;

    spmt_ram #(
        .WIDTH (V4_W),
        .DEPTH (V4_ENTRIES)
    ) u_v4_ram (
        .aclk  (aclk),
        .we    (v4_we),
        .waddr (v4_count_reg[V4_AW-1:0]),
        .wdata ({s_payload.address_low[spmt_pkg::V4_ADDR_W-1:0],
                 s_payload.prefix_length[spmt_pkg::V4_PLEN_W-1:0]}),
        .re    (v4_re),
        .raddr (ptr_reg[V4_AW-1:0]),
        .rdata (v4_rdata)
    );

    spmt_ram #(
        .WIDTH (V6_W),
        .DEPTH (V6_ENTRIES)
    ) u_v6_ram (
        .aclk  (aclk),
        .we    (v6_we),
        .waddr (v6_count_reg[V6_AW-1:0]),
        .wdata ({s_payload.address_high, s_payload.address_low, s_payload.prefix_length}),
        .re    (v6_re),
        .raddr (ptr_reg[V6_AW-1:0]),
        .rdata (v6_rdata)
    );

    always_comb begin
        if (fam_v6_reg) begin
            ent_net  = v6_rdata[V6_W-1 -: spmt_pkg::KEY_W];
            ent_plen = v6_rdata[spmt_pkg::V6_PLEN_W-1:0];
        end else begin
            ent_net  = {v4_rdata[V4_W-1 -: spmt_pkg::V4_ADDR_W],
                        {(spmt_pkg::KEY_W - spmt_pkg::V4_ADDR_W){1'b0}}};
            ent_plen = 8'(v4_rdata[spmt_pkg::V4_PLEN_W-1:0]);
        end
    end

    spmt_cmp u_cmp (
        .key     (key_reg),
        .network (ent_net),
        .prefix  (ent_plen),
        .match   (match)
    );

    always_comb begin
        state_next     = state_reg;
        v4_count_next  = v4_count_reg;
        v6_count_next  = v6_count_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        cmp_idx_next   = cmp_idx_reg;
        fam_v6_next    = fam_v6_reg;
        key_next       = key_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_payload_next = '{hit: 1'b0, entry_index: 4'd0,
                                       status: spmt_pkg::STAT_OK};
                    m_valid_next   = 1'b1;
                    ptr_next       = '0;
                    case (s_payload.req_type)
                        spmt_pkg::REQ_ADD_V4: begin
                            if (s_payload.prefix_length > 8'(spmt_pkg::V4_MAX_PLEN)) begin
                                m_payload_next.status = spmt_pkg::STAT_TOO_LONG;
                            end else if (v4_full) begin
                                m_payload_next.status = spmt_pkg::STAT_FULL;
                            end else begin
                                m_payload_next.entry_index = 4'(v4_count_reg);
                                v4_count_next = v4_count_reg + 1'b1;
                            end
                        end
                        spmt_pkg::REQ_ADD_V6: begin
                            if (s_payload.prefix_length > 8'(spmt_pkg::V6_MAX_PLEN)) begin
                                m_payload_next.status = spmt_pkg::STAT_TOO_LONG;
                            end else if (v6_full) begin
                                m_payload_next.status = spmt_pkg::STAT_FULL;
                            end else begin
                                m_payload_next.entry_index = 4'(v6_count_reg);
                                v6_count_next = v6_count_reg + 1'b1;
                            end
                        end
                        spmt_pkg::REQ_CLEAR: begin
                            v4_count_next = '0;
                            v6_count_next = '0;
                        end
                        spmt_pkg::REQ_LOOKUP_V4: begin
                            fam_v6_next = 1'b0;
                            cnt_next    = CW'(v4_count_reg);
                            key_next    = {s_payload.address_low[spmt_pkg::V4_ADDR_W-1:0],
                                           {(spmt_pkg::KEY_W - spmt_pkg::V4_ADDR_W){1'b0}}};
                            if ((s_payload.address_low[spmt_pkg::V4_ADDR_W-1:0] != '0)
                                && (v4_count_reg != '0)) begin
                                m_valid_next = 1'b0;
                                state_next   = ST_FETCH;
                            end
                        end
                        spmt_pkg::REQ_LOOKUP_V6: begin
                            fam_v6_next = 1'b1;
                            cnt_next    = CW'(v6_count_reg);
                            key_next    = {s_payload.address_high, s_payload.address_low};
                            if (v6_count_reg != '0) begin
                                m_valid_next = 1'b0;
                                state_next   = ST_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                cmp_idx_next = ptr_reg;
                ptr_next     = ptr_reg + 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP: begin
                if (match) begin
                    m_payload_next = '{hit: 1'b1, entry_index: 4'(cmp_idx_reg),
                                       status: spmt_pkg::STAT_OK};
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end else if (ptr_reg == cnt_reg) begin
                    m_payload_next = '{hit: 1'b0, entry_index: 4'd0,
                                       status: spmt_pkg::STAT_OK};
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    cmp_idx_next = ptr_reg;
                    ptr_next     = ptr_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            v4_count_reg <= '0;
            v6_count_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            v4_count_reg <= v4_count_next;
            v6_count_reg <= v6_count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        cnt_reg       <= cnt_next;
        cmp_idx_reg   <= cmp_idx_next;
        fam_v6_reg    <= fam_v6_next;
        key_reg       <= key_next;
        m_payload_reg <= m_payload_next;
    end

endmodule

>>> rtl/spmt_ram.sv
// ----------------------------------------------------------------------------
// spmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spmt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/spmt_cmp.sv
// ----------------------------------------------------------------------------
// spmt_cmp
// Prefix compare unit: leading prefix bits of key and network are equal.
// ----------------------------------------------------------------------------
module spmt_cmp (
    input  logic [spmt_pkg::KEY_W-1:0] key,
    input  logic [spmt_pkg::KEY_W-1:0] network,
    input  logic [7:0]                 prefix,
    output logic                       match
);

    logic [spmt_pkg::KEY_W-1:0] mask;

    // top 'prefix' bits set; prefix of 128 or more gives all ones
    assign mask  = ~({spmt_pkg::KEY_W{1'b1}} >> prefix);
    assign match = (((key ^ network) & mask) == '0);

endmodule

>>> rtl/spmt_checker.sv
// ----------------------------------------------------------------------------
// spmt_checker
// Port-level checks for the subnet prefix match table, bound to the top.
// ----------------------------------------------------------------------------
module spmt_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input spmt_pkg::spmt_out_t m_payload,
    input logic                m_valid,
    input logic                m_ready
);

    // request taken only when the result register drains the same cycle
    a_ready_needs_free_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_ready)
        else $error("request ready while result stalled");

    // after a transfer, either a result is shown or the lookup holds off input
    a_transfer_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid || !s_ready)
        else $error("request transfer left no result and no busy");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result dropped or changed while stalled");

    // a hit always carries ok status
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.hit |-> m_payload.status == spmt_pkg::STAT_OK)
        else $error("hit with non-ok status");

endmodule

bind subnet_prefix_match_table_unit spmt_checker u_spmt_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_payload (m_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks subnet_prefix_match_table_unit: directed add, clear, lookup and unused-code
// requests, then random episodes of clears, table fills, unused codes and lookups
// near stored networks, under bursty request traffic and a varying result stall pattern.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TBL_DEPTH   = 16;
    localparam int ITEM_TARGET = 1150;
    localparam int IDLE_LIMIT  = 4000;
    localparam int END_CYCLES  = 40;

    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

    localparam int RDY_ALWAYS = 0;
    localparam int RDY_COIN   = 1;
    localparam int RDY_EVERY3 = 2;
    localparam int RDY_SPARSE = 3;

    typedef struct packed {
        logic               hold;
        spmt_pkg::spmt_in_t req;
    } pending_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    spmt_pkg::spmt_in_t   s_payload = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    spmt_pkg::spmt_out_t  m_payload;

    pending_t             req_q[$];
    spmt_pkg::spmt_out_t  predicted_q[$];

    int unsigned sent_cnt = 0;
    int unsigned recv_cnt = 0;
    int unsigned idle_cycles = 0;
    int unsigned err_cnt = 0;
    int unsigned n_lookups = 0;
    int unsigned n_hits = 0;
    int unsigned n_full = 0;
    int unsigned n_long = 0;
    int          gap_left = 0;
    int          burst_left = 1;
    int          ready_mode = RDY_ALWAYS;
    int unsigned tick = 0;

    // predictor state
    logic [31:0]  tbl4_net[TBL_DEPTH];
    logic [7:0]   tbl4_len[TBL_DEPTH];
    int           tbl4_cnt = 0;
    logic [127:0] tbl6_key[TBL_DEPTH];
    logic [7:0]   tbl6_len[TBL_DEPTH];
    int           tbl6_cnt = 0;

    // stimulus-side view of the tables, used only to aim lookups
    logic [31:0]  gen4_net[$];
    int           gen4_len[$];
    logic [127:0] gen6_key[$];
    int           gen6_len[$];
    int           gen_items = 0;
    bit           hold_next = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    subnet_prefix_match_table_unit #(
        .V4_ENTRIES(TBL_DEPTH),
        .V6_ENTRIES(TBL_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    function automatic spmt_pkg::spmt_out_t predict_result(input spmt_pkg::spmt_in_t r);
        spmt_pkg::spmt_out_t res;
        logic [31:0]  a4;
        logic [31:0]  d4;
        logic [127:0] d6;
        int           p;
        bit           found;
        res = '0;
        found = 1'b0;
        case (r.req_type)
            spmt_pkg::REQ_ADD_V4: begin
                if (r.prefix_length > spmt_pkg::V4_MAX_PLEN) begin
                    res.status = spmt_pkg::STAT_TOO_LONG;
                end else if (tbl4_cnt >= TBL_DEPTH) begin
                    res.status = spmt_pkg::STAT_FULL;
                end else begin
                    tbl4_net[tbl4_cnt] = r.address_low[31:0];
                    tbl4_len[tbl4_cnt] = r.prefix_length;
                    res.entry_index = tbl4_cnt[3:0];
                    tbl4_cnt++;
                end
            end
            spmt_pkg::REQ_ADD_V6: begin
                if (r.prefix_length > spmt_pkg::V6_MAX_PLEN) begin
                    res.status = spmt_pkg::STAT_TOO_LONG;
                end else if (tbl6_cnt >= TBL_DEPTH) begin
                    res.status = spmt_pkg::STAT_FULL;
                end else begin
                    tbl6_key[tbl6_cnt] = {r.address_high, r.address_low};
                    tbl6_len[tbl6_cnt] = r.prefix_length;
                    res.entry_index = tbl6_cnt[3:0];
                    tbl6_cnt++;
                end
            end
            spmt_pkg::REQ_CLEAR: begin
                tbl4_cnt = 0;
                tbl6_cnt = 0;
            end
            spmt_pkg::REQ_LOOKUP_V4: begin
                a4 = r.address_low[31:0];
                if (a4 != 32'd0) begin
                    for (int i = 0; i < tbl4_cnt && !found; i++) begin
                        p = int'(tbl4_len[i]);
                        d4 = a4 ^ tbl4_net[i];
                        if (p == 0 || (d4 >> (32 - p)) == 32'd0) begin
                            found = 1'b1;
                            res.hit = 1'b1;
                            res.entry_index = i[3:0];
                        end
                    end
                end
            end
            spmt_pkg::REQ_LOOKUP_V6: begin
                for (int i = 0; i < tbl6_cnt && !found; i++) begin
                    p = int'(tbl6_len[i]);
                    d6 = {r.address_high, r.address_low} ^ tbl6_key[i];
                    if (p == 0 || (d6 >> (128 - p)) == 128'd0) begin
                        found = 1'b1;
                        res.hit = 1'b1;
                        res.entry_index = i[3:0];
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_req(input logic [2:0] kind, input logic [63:0] hi,
                             input logic [63:0] lo, input logic [7:0] plen);
        pending_t pr;
        pr.hold = hold_next;
        pr.req.req_type = kind;
        pr.req.address_high = hi;
        pr.req.address_low = lo;
        pr.req.prefix_length = plen;
        req_q = {req_q, pr};
        hold_next = 1'b0;
        if (kind <= spmt_pkg::REQ_LOOKUP_V6) gen_items++;
        if (kind == spmt_pkg::REQ_ADD_V4 && plen <= spmt_pkg::V4_MAX_PLEN
            && gen4_net.size() < TBL_DEPTH) begin
            gen4_net = {gen4_net, lo[31:0]};
            gen4_len = {gen4_len, int'(plen)};
        end
        if (kind == spmt_pkg::REQ_ADD_V6 && plen <= spmt_pkg::V6_MAX_PLEN
            && gen6_key.size() < TBL_DEPTH) begin
            gen6_key = {gen6_key, {hi, lo}};
            gen6_len = {gen6_len, int'(plen)};
        end
        if (kind == spmt_pkg::REQ_CLEAR) begin
            gen4_net.delete();
            gen4_len.delete();
            gen6_key.delete();
            gen6_len.delete();
        end
    endtask

    task automatic queue_add(input bit is_v6);
        logic [7:0] plen;
        if ($urandom_range(0, 11) == 0)
            plen = is_v6 ? 8'($urandom_range(spmt_pkg::V6_MAX_PLEN + 1, 255))
                         : 8'($urandom_range(spmt_pkg::V4_MAX_PLEN + 1, 255));
        else
            plen = is_v6 ? 8'($urandom_range(0, spmt_pkg::V6_MAX_PLEN))
                         : 8'($urandom_range(0, spmt_pkg::V4_MAX_PLEN));
        queue_req(is_v6 ? spmt_pkg::REQ_ADD_V6 : spmt_pkg::REQ_ADD_V4, rand64(), rand64(), plen);
    endtask

    // lookup usually aimed at a stored network, sometimes with one bit inside the prefix flipped
    task automatic queue_near_lookup(input bit is_v6);
        int           e;
        int           p;
        logic [31:0]  a4;
        logic [127:0] k6;
        logic [63:0]  lo;
        lo = rand64();
        if (!is_v6) begin
            if (gen4_net.size() == 0 || $urandom_range(0, 6) == 0) begin
                if ($urandom_range(0, 9) == 0) lo[31:0] = 32'd0;
            end else begin
                e = $urandom_range(0, gen4_net.size() - 1);
                p = gen4_len[e];
                a4 = gen4_net[e] ^ ($urandom & (32'hFFFF_FFFF >> p));
                if (p > 0 && $urandom_range(0, 2) == 0)
                    a4 = a4 ^ (32'h8000_0000 >> $urandom_range(0, p - 1));
                lo[31:0] = a4;
            end
            queue_req(spmt_pkg::REQ_LOOKUP_V4, rand64(), lo, 8'($urandom_range(0, 255)));
        end else begin
            k6 = {rand64(), lo};
            if (gen6_key.size() != 0 && $urandom_range(0, 6) != 0) begin
                e = $urandom_range(0, gen6_key.size() - 1);
                p = gen6_len[e];
                k6 = gen6_key[e] ^ (k6 & ({128{1'b1}} >> p));
                if (p > 0 && $urandom_range(0, 2) == 0)
                    k6 = k6 ^ (128'd1 << (127 - $urandom_range(0, p - 1)));
            end
            queue_req(spmt_pkg::REQ_LOOKUP_V6, k6[127:64], k6[63:0],
                      8'($urandom_range(0, 255)));
        end
    endtask

    // request driver
    always @(posedge aclk) begin : driver
        int unsigned sent_now;
        pending_t    nxt;
        sent_now = sent_cnt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_q = {predicted_q, predict_result(s_payload)};
                if (s_payload.req_type == spmt_pkg::REQ_LOOKUP_V4
                    || s_payload.req_type == spmt_pkg::REQ_LOOKUP_V6)
                    n_lookups++;
                sent_now = sent_cnt + 1;
                sent_cnt <= sent_now;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (req_q.size() == 0 || (req_q[0].hold && sent_now != recv_cnt)) begin
                    s_valid <= 1'b0;
                end else begin
                    nxt = req_q.pop_front();
                    s_payload <= nxt.req;
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30)
                                                               : $urandom_range(0, 4);
                    end
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : monitor
        spmt_pkg::spmt_out_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                recv_cnt <= recv_cnt + 1;
                if (predicted_q.size() == 0) begin
                    $display("%0t: unexpected result transfer hit=%0b index=%0d status=%0d",
                             $time, m_payload.hit, m_payload.entry_index, m_payload.status);
                    err_cnt++;
                end else begin
                    exp_r = predicted_q.pop_front();
                    if (exp_r.hit) n_hits++;
                    if (exp_r.status == spmt_pkg::STAT_FULL) n_full++;
                    if (exp_r.status == spmt_pkg::STAT_TOO_LONG) n_long++;
                    if (m_payload.hit !== exp_r.hit) begin
                        $display("%0t: hit mismatch expected %0b actual %0b",
                                 $time, exp_r.hit, m_payload.hit);
                        err_cnt++;
                    end
                    if (m_payload.entry_index !== exp_r.entry_index) begin
                        $display("%0t: entry_index mismatch expected %0d actual %0d",
                                 $time, exp_r.entry_index, m_payload.entry_index);
                        err_cnt++;
                    end
                    if (m_payload.status !== exp_r.status) begin
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, exp_r.status, m_payload.status);
                        err_cnt++;
                    end
                end
            end
            tick++;
            if (tick % 200 == 0) ready_mode = $urandom_range(RDY_ALWAYS, RDY_SPARSE);
            case (ready_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RDY_EVERY3: m_ready <= (tick % 3 == 0);
                default:    m_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int episode;
        int n;
        episode = 0;

        queue_req(spmt_pkg::REQ_LOOKUP_V4, rand64(), 64'h0000_0000_0A00_0001, 8'd0);
        queue_req(spmt_pkg::REQ_LOOKUP_V6, rand64(), rand64(), 8'd0);
        queue_req(spmt_pkg::REQ_ADD_V4, rand64(), {$urandom, 32'hC0A8_0100}, 8'd24);
        queue_req(spmt_pkg::REQ_LOOKUP_V4, 64'd0, {$urandom, 32'hC0A8_01FF}, 8'd0);
        queue_req(spmt_pkg::REQ_LOOKUP_V4, 64'd0, 64'h0000_0000_C0A9_0001, 8'd0);
        queue_req(spmt_pkg::REQ_ADD_V4, 64'd0, rand64(), 8'd0);
        queue_req(spmt_pkg::REQ_LOOKUP_V4, rand64(), {$urandom, 32'd0}, 8'hFF);
        queue_req(spmt_pkg::REQ_LOOKUP_V4, 64'd0, 64'h0000_0000_FFFF_FFFF, 8'd0);
        queue_req(spmt_pkg::REQ_ADD_V4, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'd32);
        queue_req(spmt_pkg::REQ_ADD_V4, rand64(), rand64(), 8'd33);
        queue_req(spmt_pkg::REQ_ADD_V4, rand64(), rand64(), 8'hFF);
        queue_req(spmt_pkg::REQ_ADD_V6, 64'd0, 64'd0, 8'd0);
        queue_req(spmt_pkg::REQ_LOOKUP_V6, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  8'd0);
        queue_req(spmt_pkg::REQ_CLEAR, rand64(), rand64(), 8'($urandom_range(0, 255)));
        queue_req(spmt_pkg::REQ_LOOKUP_V4, 64'd0, 64'h0000_0000_FFFF_FFFF, 8'd0);
        queue_req(spmt_pkg::REQ_ADD_V6, 64'h2001_0DB8_0000_0001, 64'h8000_0000_0000_0001,
                  8'd128);
        queue_req(spmt_pkg::REQ_LOOKUP_V6, 64'h2001_0DB8_0000_0001, 64'h8000_0000_0000_0001,
                  8'd0);
        queue_req(spmt_pkg::REQ_ADD_V6, rand64(), rand64(), 8'd129);
        queue_req(spmt_pkg::REQ_ADD_V6, 64'h2001_0DB8_0000_0002, 64'h0000_0000_0000_0000,
                  8'd65);
        queue_req(spmt_pkg::REQ_LOOKUP_V6, 64'h2001_0DB8_0000_0002, 64'h8000_0000_0000_0000,
                  8'd0);
        queue_req(spmt_pkg::REQ_LOOKUP_V6, 64'h2001_0DB8_0000_0002, 64'h4FFF_FFFF_FFFF_FFFF,
                  8'd0);
        queue_req(spmt_pkg::REQ_ADD_V6, 64'h2001_0DB8_0000_0003, rand64(), 8'd64);
        queue_req(spmt_pkg::REQ_LOOKUP_V6, 64'h2001_0DB8_0000_0003, rand64(), 8'd0);
        for (logic [3:0] u = {1'b0, REQ_UNUSED_FIRST}; u <= {1'b0, REQ_UNUSED_LAST}; u++)
            queue_req(u[2:0], rand64(), rand64(), 8'($urandom_range(0, 255)));
        queue_req(spmt_pkg::REQ_CLEAR, 64'd0, 64'd0, 8'd0);

        while (gen_items < ITEM_TARGET) begin
            if (episode % 8 == 3) hold_next = 1'b1;
            if ($urandom_range(0, 9) < 6)
                queue_req(spmt_pkg::REQ_CLEAR, rand64(), rand64(), 8'($urandom_range(0, 255)));
            n = $urandom_range(1, 20);
            repeat (n) queue_add(1'($urandom_range(0, 1)));
            n = $urandom_range(4, 24);
            repeat (n) begin
                case ($urandom_range(0, 19))
                    0: queue_req(3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)),
                                 rand64(), rand64(), 8'($urandom_range(0, 255)));
                    1: queue_add(1'($urandom_range(0, 1)));
                    default: queue_near_lookup(1'($urandom_range(0, 1)));
                endcase
            end
            episode++;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_q.size() != 0 || s_valid || recv_cnt != sent_cnt) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);

        $display("tb: %0d requests sent, %0d lookups with %0d hits", sent_cnt, n_lookups, n_hits);
        $display("tb: %0d full-table and %0d over-length add refusals seen", n_full, n_long);
        if (err_cnt == 0 && predicted_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
